>>> rtl/psd_pkg.sv
// Shared types and constants for the point to segment distance pipeline.
// No dependencies; every other file in the block imports this package.
package psd_pkg;

   localparam int COORD_WIDTH_DEF = 20;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int DIST_WIDTH      = 21;

   // Control that travels alongside each item from stage to stage.
   typedef struct packed {
      logic valid;
      logic zero_len;
   } ctl_type;

   // How the projection parameter is settled at the divider entry.
   typedef enum logic [1:0] {
      T_DIVIDE,
      T_ZERO,
      T_ONE
   } t_mode_type;

endpackage

>>> rtl/psd_front.sv
// Front end: coordinate differences, products and the two dot products.
// Three register stages; depends on psd_pkg.
module psd_front
   import psd_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF,
   localparam int SW = 2 * CW + 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] a [3],
   input  logic signed [CW-1:0] b [3],
   input  logic signed [CW-1:0] p [3],
   output ctl_type              ctl_out,
   output logic signed [CW:0]   d_out [3],
   output logic signed [CW:0]   w_out [3],
   output logic [SW-1:0]        segmod_out,
   output logic signed [SW-1:0] prod_out
);

   logic                      v1_ff, v2_ff;
   ctl_type                   ctl3_ff;
   logic                      zl2_ff;
   logic signed [CW:0]        d1_ff [3];
   logic signed [CW:0]        w1_ff [3];
   logic signed [CW:0]        d2_ff [3];
   logic signed [CW:0]        w2_ff [3];
   logic signed [CW:0]        d3_ff [3];
   logic signed [CW:0]        w3_ff [3];
   logic signed [2*CW+1:0]    dd_ff [3];
   logic signed [2*CW+1:0]    wd_ff [3];
   logic signed [SW-1:0]      segmod_ff;
   logic signed [SW-1:0]      prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         ctl3_ff <= '0;
      end else if (advance) begin
         v1_ff         <= in_valid;
         v2_ff         <= v1_ff;
         ctl3_ff.valid <= v2_ff;
         ctl3_ff.zero_len <= zl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= (CW+1)'(b[i]) - (CW+1)'(a[i]);
            w1_ff[i] <= (CW+1)'(p[i]) - (CW+1)'(a[i]);
            d2_ff[i] <= d1_ff[i];
            w2_ff[i] <= w1_ff[i];
            dd_ff[i] <= d1_ff[i] * d1_ff[i];
            wd_ff[i] <= w1_ff[i] * d1_ff[i];
            d3_ff[i] <= d2_ff[i];
            w3_ff[i] <= w2_ff[i];
         end
         zl2_ff    <= (d1_ff[0] == '0) && (d1_ff[1] == '0) && (d1_ff[2] == '0);
         segmod_ff <= SW'(dd_ff[0]) + SW'(dd_ff[1]) + SW'(dd_ff[2]);
         prod_ff   <= SW'(wd_ff[0]) + SW'(wd_ff[1]) + SW'(wd_ff[2]);
      end
   end

   assign ctl_out    = ctl3_ff;
   assign d_out      = d3_ff;
   assign w_out      = w3_ff;
   assign segmod_out = segmod_ff;
   assign prod_out   = prod_ff;

endmodule

>>> rtl/psd_divide.sv
// Pipelined restoring divider for the clamped projection parameter.
// One quotient bit per stage, T_FRAC_BITS stages plus entry and exit; depends on psd_pkg.
module psd_divide
   import psd_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int F  = T_FRAC_BITS_DEF,
   localparam int SW = 2 * CW + 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ctl_type              ctl_in,
   input  logic signed [CW:0]   d_in [3],
   input  logic signed [CW:0]   w_in [3],
   input  logic [SW-1:0]        segmod_in,
   input  logic signed [SW-1:0] prod_in,
   output ctl_type              ctl_out,
   output logic signed [CW:0]   d_out [3],
   output logic signed [CW:0]   w_out [3],
   output logic [F:0]           t_out
);

   localparam logic [F:0] T_ONE_VAL = {1'b1, {F{1'b0}}};

   ctl_type            ctl_ff  [0:F];
   t_mode_type         mode_ff [0:F];
   logic [SW-1:0]      rem_ff  [0:F];
   logic [SW-1:0]      den_ff  [0:F];
   logic [F-1:0]       quo_ff  [0:F];
   logic signed [CW:0] d_ff    [0:F][3];
   logic signed [CW:0] w_ff    [0:F][3];
   ctl_type            ctlo_ff;
   logic [F:0]         t_ff;
   logic signed [CW:0] do_ff [3];
   logic signed [CW:0] wo_ff [3];
   t_mode_type         mode_in;

   always_comb begin
      if (ctl_in.zero_len || prod_in[SW-1] || (prod_in == '0)) begin
         mode_in = T_ZERO;
      end else if (prod_in >= $signed(segmod_in)) begin
         mode_in = T_ONE;
      end else begin
         mode_in = T_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (advance) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff[0] <= mode_in;
         rem_ff[0]  <= prod_in[SW-1:0];
         den_ff[0]  <= segmod_in;
         quo_ff[0]  <= '0;
         d_ff[0]    <= d_in;
         w_ff[0]    <= w_in;
      end
   end

   for (genvar j = 1; j <= F; j++) begin : g_step
      logic [SW-1:0] shifted;
      logic          ge;

      assign shifted = {rem_ff[j-1][SW-2:0], 1'b0};
      assign ge      = shifted >= den_ff[j-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (advance) begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            mode_ff[j] <= mode_ff[j-1];
            rem_ff[j]  <= ge ? shifted - den_ff[j-1] : shifted;
            den_ff[j]  <= den_ff[j-1];
            quo_ff[j]  <= {quo_ff[j-1][F-2:0], ge};
            d_ff[j]    <= d_ff[j-1];
            w_ff[j]    <= w_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctlo_ff <= '0;
      end else if (advance) begin
         ctlo_ff <= ctl_ff[F];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         unique case (mode_ff[F])
            T_ZERO:   t_ff <= '0;
            T_ONE:    t_ff <= T_ONE_VAL;
            default:  t_ff <= {1'b0, quo_ff[F]};
         endcase
         do_ff <= d_ff[F];
         wo_ff <= w_ff[F];
      end
   end

   assign ctl_out = ctlo_ff;
   assign t_out   = t_ff;
   assign d_out   = do_ff;
   assign w_out   = wo_ff;

endmodule

>>> rtl/psd_project.sv
// Closest point offset, error vector and its squared length.
// Four register stages; depends on psd_pkg.
module psd_project
   import psd_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int F  = T_FRAC_BITS_DEF,
   localparam int MW = CW + F + 3,
   localparam int EW = CW + 3,
   localparam int NW = 2 * EW + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ctl_type            ctl_in,
   input  logic signed [CW:0] d_in [3],
   input  logic signed [CW:0] w_in [3],
   input  logic [F:0]         t_in,
   output ctl_type            ctl_out,
   output logic [NW-1:0]      sum_out
);

   localparam logic signed [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << (F - 1);

   ctl_type               ctl_ff [0:3];
   logic signed [MW-1:0]  m_ff  [3];
   logic signed [CW:0]    wa_ff [3];
   logic signed [EW-1:0]  e_ff  [3];
   logic [2*EW-1:0]       sq_ff [3];
   logic [NW-1:0]         sum_ff;
   logic signed [MW-1:0]  rs    [3];
   logic signed [F+1:0]   t_s;

   assign t_s = $signed({1'b0, t_in});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rs[i] = (m_ff[i] + HALF) >>> F;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) ctl_ff[k] <= '0;
      end else if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < 4; k++) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i]  <= MW'(d_in[i]) * MW'(t_s);
            wa_ff[i] <= w_in[i];
            e_ff[i]  <= EW'(wa_ff[i]) - $signed(rs[i][EW-1:0]);
            sq_ff[i] <= $unsigned((2*EW)'(e_ff[i]) * (2*EW)'(e_ff[i]));
         end
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      end
   end

   assign ctl_out = ctl_ff[3];
   assign sum_out = sum_ff;

endmodule

>>> rtl/psd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on psd_pkg for the control struct.
module psd_sqrt
   import psd_pkg::*;
#(
   parameter int NW = 48,
   localparam int R = NW / 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  ctl_type       ctl_in,
   input  logic [NW-1:0] rad_in,
   output ctl_type       ctl_out,
   output logic [R-1:0]  root_out
);

   ctl_type        ctl_ff  [0:R];
   logic [NW-1:0]  rad_ff  [0:R];
   logic [R+1:0]   rem_ff  [0:R];
   logic [R-1:0]   root_ff [0:R];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (advance) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff[0]  <= rad_in;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar j = 1; j <= R; j++) begin : g_step
      logic [R+3:0] rem_t;
      logic [R+3:0] trial;
      logic         ge;

      assign rem_t = {rem_ff[j-1], rad_ff[j-1][NW-1:NW-2]};
      assign trial = {2'b00, root_ff[j-1], 2'b01};
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (advance) begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[j]  <= {rad_ff[j-1][NW-3:0], 2'b00};
            rem_ff[j]  <= ge ? (R+2)'(rem_t - trial) : (R+2)'(rem_t);
            root_ff[j] <= {root_ff[j-1][R-2:0], ge};
         end
      end
   end

   assign ctl_out  = ctl_ff[R];
   assign root_out = root_ff[R];

endmodule

>>> rtl/point_segment_distance_3d.sv
// Distance from a 3D query point to a segment, floor of the Euclidean distance.
// Fully pipelined: one transfer accepted per cycle while no result is stalled, through the
// front, divider, projection and square root stages, with one divider stage per fraction
// bit and one square root stage per result bit. A zero-length segment returns the distance
// to the start point with zero_length set. The whole pipeline holds while a result is stalled.
// Top level; depends on psd_pkg, psd_front, psd_divide, psd_project and psd_sqrt.
module point_segment_distance_3d
   import psd_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIST_WIDTH-1:0]         rsp_distance,
   output logic                          rsp_zero_length
);

   localparam int CW = COORD_WIDTH;
   localparam int F  = T_FRAC_BITS;
   localparam int SW = 2 * CW + 4;
   localparam int NW = 2 * (CW + 3) + 2;
   localparam int R  = NW / 2;

   logic                 advance;
   logic signed [CW-1:0] a [3];
   logic signed [CW-1:0] b [3];
   logic signed [CW-1:0] p [3];
   ctl_type              ctl_f, ctl_d, ctl_p, ctl_s;
   logic signed [CW:0]   d_f [3];
   logic signed [CW:0]   w_f [3];
   logic signed [CW:0]   d_d [3];
   logic signed [CW:0]   w_d [3];
   logic [SW-1:0]        segmod;
   logic signed [SW-1:0] prod;
   logic [F:0]           t;
   logic [NW-1:0]        sum;
   logic [R-1:0]         root;

   assign a = '{req_seg_a_x, req_seg_a_y, req_seg_a_z};
   assign b = '{req_seg_b_x, req_seg_b_y, req_seg_b_z};
   assign p = '{req_point_x, req_point_y, req_point_z};

   assign advance   = !(ctl_s.valid && rsp_stall);
   assign req_stall = !advance;

   psd_front #(.CW(CW)) u_front (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .a(a), .b(b), .p(p), .ctl_out(ctl_f), .d_out(d_f), .w_out(w_f),
      .segmod_out(segmod), .prod_out(prod)
   );

   psd_divide #(.CW(CW), .F(F)) u_divide (
      .clock(clock), .reset(reset), .advance(advance), .ctl_in(ctl_f),
      .d_in(d_f), .w_in(w_f), .segmod_in(segmod), .prod_in(prod),
      .ctl_out(ctl_d), .d_out(d_d), .w_out(w_d), .t_out(t)
   );

   psd_project #(.CW(CW), .F(F)) u_project (
      .clock(clock), .reset(reset), .advance(advance), .ctl_in(ctl_d),
      .d_in(d_d), .w_in(w_d), .t_in(t), .ctl_out(ctl_p), .sum_out(sum)
   );

   psd_sqrt #(.NW(NW)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance), .ctl_in(ctl_p),
      .rad_in(sum), .ctl_out(ctl_s), .root_out(root)
   );

   assign rsp_valid       = ctl_s.valid;
   assign rsp_distance    = DIST_WIDTH'(root);
   assign rsp_zero_length = ctl_s.zero_len;

   a_t_bounded: assert property (@(posedge clock) disable iff (reset)
      ctl_d.valid |-> (t <= {1'b1, {F{1'b0}}}))
      else $error("projection parameter exceeds one");

   a_zero_len_t: assert property (@(posedge clock) disable iff (reset)
      (ctl_d.valid && ctl_d.zero_len) |-> (t == '0))
      else $error("zero-length segment with non-zero projection");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_distance) && $stable(rsp_zero_length)))
      else $error("stalled result changed or was dropped");

endmodule

>>> test/psd_checker.sv
`timescale 1ns / 1ps
// Checker for point_segment_distance_3d: watches both channels, predicts each distance
// and compares it with the result transfers in order. Depends on psd_pkg only.
module psd_checker
   import psd_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_seg_a_x,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_seg_a_y,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_seg_a_z,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_seg_b_x,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_seg_b_y,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_seg_b_z,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_point_x,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_point_y,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_point_z,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [DIST_WIDTH-1:0]             rsp_distance,
   input  logic                              rsp_zero_length,
   output int                                failures,
   output int                                distances_due,
   output int                                distances_checked,
   output int                                degenerate_seen
);

   localparam int FRAC = T_FRAC_BITS_DEF;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  zero_length;
   } distance_type;

   distance_type distance_queue[$];

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic distance_type nearest_distance(
      input longint ax, input longint ay, input longint az,
      input longint bx, input longint by, input longint bz,
      input longint px, input longint py, input longint pz);
      longint dv[3];
      longint wv[3];
      longint seg_len_sq, dot_wd, t_frac, offset, err;
      longint unsigned err_sq;
      distance_type res;
      dv[0] = bx - ax; dv[1] = by - ay; dv[2] = bz - az;
      wv[0] = px - ax; wv[1] = py - ay; wv[2] = pz - az;
      seg_len_sq = 0;
      dot_wd = 0;
      err_sq = 0;
      for (int i = 0; i < 3; i++) begin
         seg_len_sq += dv[i] * dv[i];
         dot_wd += wv[i] * dv[i];
      end
      if (seg_len_sq == 0 || dot_wd <= 0) t_frac = 0;
      else if (dot_wd >= seg_len_sq) t_frac = longint'(1) << FRAC;
      else t_frac = (dot_wd << FRAC) / seg_len_sq;
      for (int i = 0; i < 3; i++) begin
         offset = (dv[i] * t_frac + (longint'(1) << (FRAC - 1))) >>> FRAC;
         err = wv[i] - offset;
         err_sq += longint'(err * err);
      end
      res.distance = DIST_WIDTH'(floor_sqrt(err_sq));
      res.zero_length = (seg_len_sq == 0);
      return res;
   endfunction

   initial begin
      failures = 0;
      distances_checked = 0;
      degenerate_seen = 0;
   end

   assign distances_due = distance_queue.size();

   always @(posedge clock) begin
      distance_type want;
      distance_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = nearest_distance(req_seg_a_x, req_seg_a_y, req_seg_a_z,
                                    req_seg_b_x, req_seg_b_y, req_seg_b_z,
                                    req_point_x, req_point_y, req_point_z);
            if (want.zero_length) degenerate_seen++;
            distance_queue.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.distance = rsp_distance;
            got.zero_length = rsp_zero_length;
            if (distance_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("Unexpected result transfer: distance %0d zero_length %0d",
                           got.distance, got.zero_length);
            end else begin
               want = distance_queue.pop_front();
               distances_checked++;
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display("Mismatch at result %0d: distance %0d/%0d, zero_length %0d/%0d",
                              distances_checked, want.distance, got.distance,
                              want.zero_length, got.zero_length);
               end
            end
         end
      end
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the point_segment_distance_3d testbench: clock, reset, stimulus and verdict.
// Depends on psd_pkg, the block and psd_checker.
module testbench;
   import psd_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 1650;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef logic signed [CW-1:0] coord_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   coord_type req_coord[9];
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [DIST_WIDTH-1:0] rsp_distance;
   logic rsp_zero_length;
   int failures, distances_due, distances_checked, degenerate_seen;
   int items_sent = 0;
   bit sender_busy = 1;

   initial for (int i = 0; i < 9; i++) req_coord[i] = '0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   point_segment_distance_3d uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_seg_a_x(req_coord[0]), .req_seg_a_y(req_coord[1]), .req_seg_a_z(req_coord[2]),
      .req_seg_b_x(req_coord[3]), .req_seg_b_y(req_coord[4]), .req_seg_b_z(req_coord[5]),
      .req_point_x(req_coord[6]), .req_point_y(req_coord[7]), .req_point_z(req_coord[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance), .rsp_zero_length(rsp_zero_length)
   );

   psd_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_seg_a_x(req_coord[0]), .req_seg_a_y(req_coord[1]), .req_seg_a_z(req_coord[2]),
      .req_seg_b_x(req_coord[3]), .req_seg_b_y(req_coord[4]), .req_seg_b_z(req_coord[5]),
      .req_point_x(req_coord[6]), .req_point_y(req_coord[7]), .req_point_z(req_coord[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance), .rsp_zero_length(rsp_zero_length),
      .failures(failures), .distances_due(distances_due),
      .distances_checked(distances_checked), .degenerate_seen(degenerate_seen)
   );

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // The receiver stalls at random, except for one quiet stretch, and once holds off
   // for a long stretch so that the pipeline fills and stalls the sender.
   initial begin
      int cycle;
      cycle = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle >= 1000 && cycle < 1300) rsp_stall <= 1;
         else if (cycle >= 1600 && cycle < 2000) rsp_stall <= 0;
         else rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   task automatic send_item(input coord_type c[9], input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(0, 99) < 30) begin
            @(negedge clock);
            req_valid <= 0;
         end
      end
      @(negedge clock);
      req_valid <= 1;
      for (int i = 0; i < 9; i++) req_coord[i] <= c[i];
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic coord_type any_coord();
      return coord_type'($urandom());
   endfunction

   function automatic coord_type near_coord(input coord_type base, input int spread);
      return base + coord_type'($urandom_range(0, 2 * spread) - spread);
   endfunction

   task automatic random_item(output coord_type c[9]);
      int kind;
      int scale;
      coord_type centre;
      kind = $urandom_range(0, 9);
      centre = any_coord();
      case (kind)
         0, 1, 2: begin
            for (int i = 0; i < 9; i++) c[i] = any_coord();
         end
         3, 4: begin
            for (int i = 0; i < 9; i++) c[i] = near_coord(centre, 300);
         end
         5: begin
            // Degenerate segment: both end points coincide.
            for (int i = 0; i < 3; i++) begin
               c[i] = any_coord();
               c[3 + i] = c[i];
               c[6 + i] = ($urandom_range(0, 1)) ? any_coord() : near_coord(c[i], 50);
            end
         end
         6, 7: begin
            // Point projecting before the start, past the end, or in between.
            scale = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
               c[i] = near_coord(centre, 4000);
               c[3 + i] = near_coord(centre, 4000);
               case (scale)
                  0: c[6 + i] = c[i] - (c[3 + i] - c[i]) + coord_type'($urandom_range(0, 20));
                  1: c[6 + i] = c[3 + i] + (c[3 + i] - c[i]) + coord_type'($urandom_range(0, 20));
                  default: c[6 + i] = near_coord(c[i] + ((c[3 + i] - c[i]) >>> 1), 30);
               endcase
            end
         end
         default: begin
            for (int i = 0; i < 9; i++)
               case ($urandom_range(0, 3))
                  0: c[i] = CMAX;
                  1: c[i] = CMIN;
                  2: c[i] = '0;
                  default: c[i] = any_coord();
               endcase
         end
      endcase
   endtask

   task automatic set_item(output coord_type c[9], input coord_type a0, a1, a2,
                           b0, b1, b2, p0, p1, p2);
      c[0] = a0; c[1] = a1; c[2] = a2;
      c[3] = b0; c[4] = b1; c[5] = b2;
      c[6] = p0; c[7] = p1; c[8] = p2;
   endtask

   initial begin
      coord_type c[9];
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      set_item(c, 0, 0, 0, 0, 0, 0, 0, 0, 0);             send_item(c, 0);
      set_item(c, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN); send_item(c, 0);
      set_item(c, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX); send_item(c, 0);
      set_item(c, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX); send_item(c, 0);
      set_item(c, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, 0, 0);          send_item(c, 0);
      set_item(c, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN); send_item(c, 0);
      set_item(c, 0, 0, 0, 100, 0, 0, -50, 30, 0);         send_item(c, 0);
      set_item(c, 0, 0, 0, 100, 0, 0, 170, 0, -40);        send_item(c, 0);
      set_item(c, 0, 0, 0, 100, 0, 0, 37, 25, 0);          send_item(c, 0);
      set_item(c, 0, 0, 0, 0, 200, 0, 7, 101, 0);          send_item(c, 0);
      set_item(c, 0, 0, 0, 0, 0, 300, 0, 9, 150);          send_item(c, 0);
      set_item(c, 5, 5, 5, 5, 5, 5, 8, 9, 5);              send_item(c, 0);
      set_item(c, 0, 0, 0, 3, 0, 0, 1, 7, 0);              send_item(c, 0);
      set_item(c, -10, -10, -10, 10, 10, 10, 0, 0, 0);     send_item(c, 0);
      set_item(c, 0, 0, 0, 1, 1, 1, CMAX, CMAX, CMAX);     send_item(c, 0);
      set_item(c, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX); send_item(c, 0);
      set_item(c, -1, -1, -1, -1, -1, -1, CMIN, CMAX, 0);  send_item(c, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         random_item(c);
         send_item(c, !(n >= 600 && n < 900));
      end
      @(negedge clock);
      req_valid <= 0;

      while (distances_due != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d segment queries, %0d results checked, %0d with degenerate segments.",
               items_sent, distances_checked, degenerate_seen);
      $display("Mismatches or stray results: %0d, results still awaited: %0d.",
               failures, distances_due);
      if (failures == 0 && distances_due == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
